[src/pgf_pkg.sv]
package pgf_pkg;

    // field widths fixed by the interface
    localparam int GRAV_W     = 32;
    localparam int DIST_W     = 48;
    localparam int MASS_W     = 32;
    localparam int MAG_W      = 64;
    localparam int NUM_W      = GRAV_W + 2 * MASS_W;
    localparam int HALF_W     = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 48;
    localparam int FIFO_DEPTH = 4;

    // parameter defaults
    localparam int FRAC_BITS_DEF   = 16;
    localparam int COORD_WIDTH_DEF = 32;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_D2  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_D2  = 2'd2;

    // reset values
    localparam logic [GRAV_W-1:0] GRAV_RST   = 32'h0001_0000;
    localparam logic [DIST_W-1:0] MIN_D2_RST = 48'h0000_0001_0000;
    localparam logic [DIST_W-1:0] D2_MAX     = 48'hFFFF_FFFF_FFFF;

    typedef struct packed {
        logic [GRAV_W-1:0] gravity;
        logic [DIST_W-1:0] min_d2;
        logic [DIST_W-1:0] max_d2;
    } cfg_t;

    // width of one queued item: s, num, divisor, |dx|, |dy|, signs, zero
    function automatic int pgf_item_w(input int cw, input int fb);
        return 4 * (cw + 1) + NUM_W + DIST_W + fb + 3;
    endfunction

endpackage

[src/pgf_fifo.sv]
module pgf_fifo
    import pgf_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = FIFO_DEPTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             push, pop;

    assign in_ready  = (count_reg != CNT_W'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue fill count beyond depth");

    a_count_up: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not follow a push");

endmodule

[src/pgf_front.sv]
module pgf_front
    import pgf_pkg::*;
#(
    parameter int FRAC_BITS   = FRAC_BITS_DEF,
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int ITEM_W      = pgf_item_w(COORD_WIDTH_DEF, FRAC_BITS_DEF)
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  cfg_t                   cfg,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [COORD_WIDTH-1:0] body_a_x,
    input  logic [COORD_WIDTH-1:0] body_a_y,
    input  logic [COORD_WIDTH-1:0] body_b_x,
    input  logic [COORD_WIDTH-1:0] body_b_y,
    input  logic [MASS_W-1:0]      mass_a,
    input  logic [MASS_W-1:0]      mass_b,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [ITEM_W-1:0]      out_item
);

    localparam int CW  = COORD_WIDTH;
    localparam int AW  = CW + 1;
    localparam int SW  = 2 * AW;
    localparam int DVW = DIST_W + FRAC_BITS;
    localparam int XW  = (SW > DVW) ? SW : DVW;

    typedef struct packed {
        logic [SW-1:0]    s;
        logic [NUM_W-1:0] num;
        logic [DVW-1:0]   dvs;
        logic [AW-1:0]    adx;
        logic [AW-1:0]    ady;
        logic             negx;
        logic             negy;
        logic             zero;
    } item_t;

    typedef struct packed {
        logic [AW-1:0] adx;
        logic [AW-1:0] ady;
        logic          negx;
        logic          negy;
        logic          zero;
    } geom_t;

    logic                 ce;
    logic                 v1_reg, v2_reg, v3_reg, v4_reg;
    geom_t                g1_reg, g2_reg, g3_reg, g1_next;
    logic [MAG_W-1:0]     gma1_reg;
    logic [MASS_W-1:0]    mb1_reg;
    logic [SW-1:0]        sqx2_reg, sqy2_reg, s3_reg;
    logic [MAG_W-1:0]     gl2_reg, gh2_reg;
    logic [NUM_W-1:0]     num3_reg;
    item_t                item4_reg, item4_next;
    logic [AW-1:0]        dx, dy;
    logic [XW-1:0]        s_shift;
    logic [DIST_W-1:0]    d2, c_lo, c_hi;

    // whole front advances together
    assign ce        = !v4_reg || out_ready;
    assign in_ready  = ce;
    assign out_valid = v4_reg;
    assign out_item  = item4_reg;

    // difference vector and its sign/magnitude form
    always_comb begin
        dx = {body_b_x[CW-1], body_b_x} - {body_a_x[CW-1], body_a_x};
        dy = {body_b_y[CW-1], body_b_y} - {body_a_y[CW-1], body_a_y};
        g1_next.negx = dx[AW-1];
        g1_next.negy = dy[AW-1];
        g1_next.adx  = dx[AW-1] ? (~dx + 1'b1) : dx;
        g1_next.ady  = dy[AW-1] ? (~dy + 1'b1) : dy;
        g1_next.zero = (dx == '0) && (dy == '0);
    end

    // squared distance, clamp and divisor
    always_comb begin
        s_shift = XW'(s3_reg) >> FRAC_BITS;
        d2      = (s_shift > XW'(D2_MAX)) ? D2_MAX : s_shift[DIST_W-1:0];
        c_lo    = (d2 < cfg.min_d2) ? cfg.min_d2 : d2;
        c_hi    = (c_lo > cfg.max_d2) ? cfg.max_d2 : c_lo;
        item4_next.s    = s3_reg;
        item4_next.num  = num3_reg;
        item4_next.dvs  = (c_hi == '0) ? (DVW'(1) << FRAC_BITS)
                                       : (DVW'(c_hi) << FRAC_BITS);
        item4_next.adx  = g3_reg.adx;
        item4_next.ady  = g3_reg.ady;
        item4_next.negx = g3_reg.negx;
        item4_next.negy = g3_reg.negy;
        item4_next.zero = g3_reg.zero;
    end

    // datapath stages
    always_ff @(posedge aclk) begin
        if (ce) begin
            g1_reg   <= g1_next;
            gma1_reg <= MAG_W'(cfg.gravity) * MAG_W'(mass_a);
            mb1_reg  <= mass_b;

            g2_reg   <= g1_reg;
            sqx2_reg <= SW'(g1_reg.adx) * SW'(g1_reg.adx);
            sqy2_reg <= SW'(g1_reg.ady) * SW'(g1_reg.ady);
            gl2_reg  <= MAG_W'(gma1_reg[HALF_W-1:0]) * MAG_W'(mb1_reg);
            gh2_reg  <= MAG_W'(gma1_reg[MAG_W-1:HALF_W]) * MAG_W'(mb1_reg);

            g3_reg   <= g2_reg;
            s3_reg   <= sqx2_reg + sqy2_reg;
            num3_reg <= (NUM_W'(gh2_reg) << HALF_W) + NUM_W'(gl2_reg);

            item4_reg <= item4_next;
        end
    end

    // stage valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (ce) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

endmodule

[src/pgf_back.sv]
module pgf_back
    import pgf_pkg::*;
#(
    parameter int FRAC_BITS   = FRAC_BITS_DEF,
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int ITEM_W      = pgf_item_w(COORD_WIDTH_DEF, FRAC_BITS_DEF)
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [ITEM_W-1:0]      in_item,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [COORD_WIDTH-1:0] force_x,
    output logic [COORD_WIDTH-1:0] force_y,
    output logic                   saturated
);

    localparam int CW  = COORD_WIDTH;
    localparam int AW  = CW + 1;
    localparam int SW  = 2 * AW;
    localparam int LW  = AW;
    localparam int DVW = DIST_W + FRAC_BITS;
    localparam int PRW = HALF_W + AW;
    localparam int PW  = MAG_W + AW;
    localparam int HW  = PW - CW;

    typedef struct packed {
        logic [SW-1:0]    s;
        logic [NUM_W-1:0] num;
        logic [DVW-1:0]   dvs;
        logic [AW-1:0]    adx;
        logic [AW-1:0]    ady;
        logic             negx;
        logic             negy;
        logic             zero;
    } item_t;

    // magnitude divider and square root run side by side
    typedef struct packed {
        logic [DVW-1:0]   mrem;
        logic [MAG_W-1:0] mq;
        logic [MAG_W-1:0] mlow;
        logic [DVW-1:0]   dvs;
        logic             msat;
        logic [LW:0]      srem;
        logic [LW-1:0]    sroot;
        logic [SW-1:0]    sbits;
        logic [AW-1:0]    adx;
        logic [AW-1:0]    ady;
        logic             negx;
        logic             negy;
        logic             zero;
    } p1_t;

    typedef struct packed {
        logic [PRW-1:0] plx;
        logic [PRW-1:0] phx;
        logic [PRW-1:0] ply;
        logic [PRW-1:0] phy;
        logic [LW-1:0]  len;
        logic           negx;
        logic           negy;
        logic           zero;
    } m1_t;

    typedef struct packed {
        logic [PW-1:0] px;
        logic [PW-1:0] py;
        logic [LW-1:0] len;
        logic          negx;
        logic          negy;
        logic          zero;
    } m2_t;

    // one component divider lane
    typedef struct packed {
        logic [LW-1:0] rem;
        logic [CW-1:0] q;
        logic [CW-1:0] low;
        logic [LW-1:0] len;
        logic          sat;
        logic          neg;
        logic          zero;
    } c_t;

    function automatic p1_t p1_step(input p1_t a, input logic do_sqrt);
        p1_t         r;
        logic [DVW:0] mt, md;
        logic [LW+2:0] st, sd, trial;
        r  = a;
        mt = {a.mrem, a.mlow[MAG_W-1]};
        md = mt - {1'b0, a.dvs};
        if (mt >= {1'b0, a.dvs}) begin
            r.mrem = md[DVW-1:0];
            r.mq   = {a.mq[MAG_W-2:0], 1'b1};
        end else begin
            r.mrem = mt[DVW-1:0];
            r.mq   = {a.mq[MAG_W-2:0], 1'b0};
        end
        r.mlow = a.mlow << 1;
        st    = {a.srem, a.sbits[SW-1:SW-2]};
        trial = {1'b0, a.sroot, 2'b01};
        sd    = st - trial;
        if (do_sqrt) begin
            if (st >= trial) begin
                r.srem  = sd[LW:0];
                r.sroot = {a.sroot[LW-2:0], 1'b1};
            end else begin
                r.srem  = st[LW:0];
                r.sroot = {a.sroot[LW-2:0], 1'b0};
            end
            r.sbits = a.sbits << 2;
        end
        return r;
    endfunction

    function automatic c_t c_init(input logic [PW-1:0] p, input logic [LW-1:0] len,
                                  input logic neg, input logic zero);
        c_t r;
        logic [HW-1:0] hi;
        hi     = p[PW-1:CW];
        r.sat  = (hi >= HW'(len));
        r.rem  = r.sat ? '0 : hi[LW-1:0];
        r.q    = '0;
        r.low  = p[CW-1:0];
        r.len  = len;
        r.neg  = neg;
        r.zero = zero;
        return r;
    endfunction

    function automatic c_t c_step(input c_t a);
        c_t        r;
        logic [LW:0] t, d;
        r = a;
        t = {a.rem, a.low[CW-1]};
        d = t - {1'b0, a.len};
        if (t >= {1'b0, a.len}) begin
            r.rem = d[LW-1:0];
            r.q   = {a.q[CW-2:0], 1'b1};
        end else begin
            r.rem = t[LW-1:0];
            r.q   = {a.q[CW-2:0], 1'b0};
        end
        r.low = a.low << 1;
        return r;
    endfunction

    // sign, clip, flag: returns {flag, value}
    function automatic logic [CW:0] c_resolve(input c_t a);
        logic [CW-1:0] cap, m;
        logic          clip;
        cap  = a.neg ? (CW'(1) << (CW - 1)) : ((CW'(1) << (CW - 1)) - 1'b1);
        clip = a.sat || (a.q > cap);
        m    = clip ? cap : a.q;
        if (a.zero) begin
            return '0;
        end
        return {clip, a.neg ? (~m + 1'b1) : m};
    endfunction

    item_t          item;
    p1_t            p1_init;
    p1_t            p1_reg [MAG_W];
    logic [MAG_W-1:0] p1_vld_reg;
    m1_t            m1_reg, m1_next;
    m2_t            m2_reg;
    logic           m1_vld_reg, m2_vld_reg;
    c_t             cx_reg [CW];
    c_t             cy_reg [CW];
    logic [CW-1:0]  c_vld_reg;
    logic           out_vld_reg, sat_reg;
    logic [CW-1:0]  fx_reg, fy_reg;
    logic [MAG_W-1:0] mag;
    logic [CW:0]    rx, ry;
    logic           ce;

    assign item      = item_t'(in_item);
    assign ce        = !out_vld_reg || out_ready;
    assign in_ready  = ce;
    assign out_valid = out_vld_reg;
    assign force_x   = fx_reg;
    assign force_y   = fy_reg;
    assign saturated = sat_reg;

    // load a queued item into the divider / root chain
    always_comb begin
        p1_init.msat  = (DVW'(item.num[NUM_W-1:MAG_W]) >= item.dvs);
        p1_init.mrem  = p1_init.msat ? '0 : DVW'(item.num[NUM_W-1:MAG_W]);
        p1_init.mq    = '0;
        p1_init.mlow  = item.num[MAG_W-1:0];
        p1_init.dvs   = item.dvs;
        p1_init.srem  = '0;
        p1_init.sroot = '0;
        p1_init.sbits = item.s;
        p1_init.adx   = item.adx;
        p1_init.ady   = item.ady;
        p1_init.negx  = item.negx;
        p1_init.negy  = item.negy;
        p1_init.zero  = item.zero;
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            p1_reg[0] <= p1_step(p1_init, 1'b1);
        end
    end

    // one quotient bit per stage; one root bit in each of the first LW stages
    for (genvar j = 1; j < MAG_W; j++) begin : g_p1
        always_ff @(posedge aclk) begin
            if (ce) begin
                p1_reg[j] <= p1_step(p1_reg[j-1], (j < LW));
            end
        end
    end

    // split product: magnitude halves times |d|
    always_comb begin
        mag = p1_reg[MAG_W-1].msat ? '1 : p1_reg[MAG_W-1].mq;
        m1_next.plx  = PRW'(mag[HALF_W-1:0]) * PRW'(p1_reg[MAG_W-1].adx);
        m1_next.phx  = PRW'(mag[MAG_W-1:HALF_W]) * PRW'(p1_reg[MAG_W-1].adx);
        m1_next.ply  = PRW'(mag[HALF_W-1:0]) * PRW'(p1_reg[MAG_W-1].ady);
        m1_next.phy  = PRW'(mag[MAG_W-1:HALF_W]) * PRW'(p1_reg[MAG_W-1].ady);
        m1_next.len  = p1_reg[MAG_W-1].zero ? LW'(1) : p1_reg[MAG_W-1].sroot;
        m1_next.negx = p1_reg[MAG_W-1].negx;
        m1_next.negy = p1_reg[MAG_W-1].negy;
        m1_next.zero = p1_reg[MAG_W-1].zero;
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            m1_reg     <= m1_next;
            m2_reg.px  <= (PW'(m1_reg.phx) << HALF_W) + PW'(m1_reg.plx);
            m2_reg.py  <= (PW'(m1_reg.phy) << HALF_W) + PW'(m1_reg.ply);
            m2_reg.len <= m1_reg.len;
            m2_reg.negx <= m1_reg.negx;
            m2_reg.negy <= m1_reg.negy;
            m2_reg.zero <= m1_reg.zero;
            cx_reg[0] <= c_step(c_init(m2_reg.px, m2_reg.len, m2_reg.negx, m2_reg.zero));
            cy_reg[0] <= c_step(c_init(m2_reg.py, m2_reg.len, m2_reg.negy, m2_reg.zero));
        end
    end

    // component division, one bit per stage
    for (genvar k = 1; k < CW; k++) begin : g_c
        always_ff @(posedge aclk) begin
            if (ce) begin
                cx_reg[k] <= c_step(cx_reg[k-1]);
                cy_reg[k] <= c_step(cy_reg[k-1]);
            end
        end
    end

    // output register
    assign rx = c_resolve(cx_reg[CW-1]);
    assign ry = c_resolve(cy_reg[CW-1]);

    always_ff @(posedge aclk) begin
        if (ce) begin
            fx_reg  <= rx[CW-1:0];
            fy_reg  <= ry[CW-1:0];
            sat_reg <= rx[CW] || ry[CW];
        end
    end

    // stage valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_vld_reg  <= '0;
            m1_vld_reg  <= 1'b0;
            m2_vld_reg  <= 1'b0;
            c_vld_reg   <= '0;
            out_vld_reg <= 1'b0;
        end else if (ce) begin
            p1_vld_reg  <= {p1_vld_reg[MAG_W-2:0], in_valid};
            m1_vld_reg  <= p1_vld_reg[MAG_W-1];
            m2_vld_reg  <= m1_vld_reg;
            c_vld_reg   <= {c_vld_reg[CW-2:0], m2_vld_reg};
            out_vld_reg <= c_vld_reg[CW-1];
        end
    end

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !ce |=> ($stable(p1_vld_reg) && $stable(c_vld_reg)))
        else $error("pipeline moved during a stall");

endmodule

[src/pairwise_gravity_force_2d.sv]
// Channel  Dir  Handshake              Payload
// s_       in   s_tvalid / s_tready    s_tdata: a_x, a_y, b_x, b_y, mass_a, mass_b
// m_       out  m_tvalid / m_tready    m_tdata: force_x, force_y; m_tuser: saturated
// cfg_     in   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One beat is taken per cycle unless a stall on m_ has filled the queue; results
// pass through the 64-stage force magnitude divider and then the COORD_WIDTH-stage
// component dividers.
// aresetn is synchronous; it empties every stage and loads register defaults.
// A stall on m_ holds the back pipeline; the front keeps taking beats until the
// four-entry queue between them fills. cfg_ready is always high.
module pairwise_gravity_force_2d
    import pgf_pkg::*;
#(
    parameter int FRAC_BITS   = FRAC_BITS_DEF,
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    localparam int IN_TDW  = ((4 * COORD_WIDTH + 2 * MASS_W + 7) / 8) * 8,
    localparam int OUT_TDW = ((2 * COORD_WIDTH + 7) / 8) * 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // body_a_x, body_a_y, body_b_x, body_b_y, mass_a, mass_b
    input  logic [IN_TDW-1:0]     s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // force_x, force_y
    output logic [OUT_TDW-1:0]    m_tdata,
    // saturated
    output logic                  m_tuser,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int CW     = COORD_WIDTH;
    localparam int ITEM_W = pgf_item_w(COORD_WIDTH, FRAC_BITS);

    cfg_t              cfg_reg;
    logic              q_in_valid, q_in_ready, q_out_valid, q_out_ready;
    logic [ITEM_W-1:0] q_in_item, q_out_item;
    logic [CW-1:0]     force_x, force_y;

    assign cfg_ready = 1'b1;

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.gravity <= GRAV_RST;
            cfg_reg.min_d2  <= MIN_D2_RST;
            cfg_reg.max_d2  <= D2_MAX;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_GRAVITY: cfg_reg.gravity <= cfg_data[GRAV_W-1:0];
                CFG_MIN_D2:  cfg_reg.min_d2  <= cfg_data[DIST_W-1:0];
                CFG_MAX_D2:  cfg_reg.max_d2  <= cfg_data[DIST_W-1:0];
                default: begin
                end
            endcase
        end
    end

    pgf_front #(
        .FRAC_BITS  (FRAC_BITS),
        .COORD_WIDTH(COORD_WIDTH),
        .ITEM_W     (ITEM_W)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .body_a_x (s_tdata[CW-1:0]),
        .body_a_y (s_tdata[2*CW-1:CW]),
        .body_b_x (s_tdata[3*CW-1:2*CW]),
        .body_b_y (s_tdata[4*CW-1:3*CW]),
        .mass_a   (s_tdata[4*CW+MASS_W-1:4*CW]),
        .mass_b   (s_tdata[4*CW+2*MASS_W-1:4*CW+MASS_W]),
        .out_valid(q_in_valid),
        .out_ready(q_in_ready),
        .out_item (q_in_item)
    );

    pgf_fifo #(
        .WIDTH(ITEM_W),
        .DEPTH(FIFO_DEPTH)
    ) u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (q_in_valid),
        .in_ready (q_in_ready),
        .in_data  (q_in_item),
        .out_valid(q_out_valid),
        .out_ready(q_out_ready),
        .out_data (q_out_item)
    );

    pgf_back #(
        .FRAC_BITS  (FRAC_BITS),
        .COORD_WIDTH(COORD_WIDTH),
        .ITEM_W     (ITEM_W)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (q_out_valid),
        .in_ready (q_out_ready),
        .in_item  (q_out_item),
        .out_valid(m_tvalid),
        .out_ready(m_tready),
        .force_x  (force_x),
        .force_y  (force_y),
        .saturated(m_tuser)
    );

    assign m_tdata = OUT_TDW'({force_y, force_x});

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;
    import pgf_pkg::*;

    localparam int IN_TDW  = ((4 * 32 + 2 * MASS_W + 7) / 8) * 8;
    localparam int OUT_TDW = ((2 * 32 + 7) / 8) * 8;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int DRAIN_CYCLES = 160;
    localparam int STALL_LIMIT  = 20000;
    localparam int MAX_REPORTS  = 10;
    localparam int RAND_PER_PHASE = 364;

    typedef struct packed {
        logic [31:0] mb;
        logic [31:0] ma;
        logic [31:0] by;
        logic [31:0] bx;
        logic [31:0] ay;
        logic [31:0] ax;
    } body_pair_t;

    typedef struct packed {
        logic        sat;
        logic [31:0] fy;
        logic [31:0] fx;
    } force_t;

    typedef struct {
        body_pair_t pair;
        bit         typed;
        force_t     want;
    } stim_row_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_TDW-1:0]     s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_TDW-1:0]    m_tdata;
    logic                  m_tuser;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // local copy of the register file
    logic [GRAV_W-1:0] g_const;
    logic [DIST_W-1:0] d2_floor;
    logic [DIST_W-1:0] d2_ceil;

    force_t pending_forces[$];
    int     error_count;
    int     quiet;
    int     hold_cycles;
    int     dead_cycles;

    pairwise_gravity_force_2d dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // floor(sqrt(v)); v stays below 2^66
    function automatic logic [127:0] int_sqrt(input logic [127:0] v);
        logic [127:0] root;
        logic [127:0] trial;
        root = '0;
        for (int i = 40; i >= 0; i--) begin
            trial = root | (128'd1 << i);
            if (trial * trial <= v) root = trial;
        end
        return root;
    endfunction

    // one force component: mag*|d|/len, sign of d, clipped to 32 bits
    function automatic logic [31:0] resolve_axis(input logic neg, input logic [32:0] ad,
                                                 input logic [63:0] mag,
                                                 input logic [127:0] len, inout logic sat);
        logic [127:0] q;
        logic [127:0] cap;
        logic [31:0]  m;
        q   = (128'(mag) * 128'(ad)) / len;
        cap = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
        if (q > cap) begin
            q   = cap;
            sat = 1'b1;
        end
        m = q[31:0];
        return neg ? -m : m;
    endfunction

    function automatic force_t gravity_force(input body_pair_t p);
        logic signed [32:0] dx, dy;
        logic [32:0]  adx, ady;
        logic [127:0] s, ds, num, den, q, len;
        logic [47:0]  d2, c;
        logic [63:0]  mag;
        logic         sat;
        force_t       r;
        dx = {p.bx[31], p.bx} - {p.ax[31], p.ax};
        dy = {p.by[31], p.by} - {p.ay[31], p.ay};
        if (dx == 0 && dy == 0) return '0;
        adx = dx[32] ? -dx : dx;
        ady = dy[32] ? -dy : dy;
        s   = 128'(adx) * 128'(adx) + 128'(ady) * 128'(ady);
        ds  = s >> 16;
        d2  = (ds > 128'(D2_MAX)) ? D2_MAX : ds[47:0];
        c   = (d2 < d2_floor) ? d2_floor : d2;
        if (c > d2_ceil) c = d2_ceil;
        if (c == 0) c = 48'd1;
        len = int_sqrt(s);
        num = 128'(g_const) * 128'(p.ma) * 128'(p.mb);
        den = 128'(c) << 16;
        q   = num / den;
        mag = (q[127:64] != 0) ? '1 : q[63:0];
        sat = 1'b0;
        r.fx  = resolve_axis(dx[32], adx, mag, len, sat);
        r.fy  = resolve_axis(dy[32], ady, mag, len, sat);
        r.sat = sat;
        return r;
    endfunction

    // offer one pair, record its expected force once the beat is taken
    task automatic send_pair(input body_pair_t p, input bit typed, input force_t want);
        @(negedge aclk);
        while (!quiet && $urandom_range(99) < 30) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= p;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_forces.push_back(typed ? want : gravity_force(p));
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        s_tvalid  <= 1'b0;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            CFG_GRAVITY: g_const  = val[GRAV_W-1:0];
            CFG_MIN_D2:  d2_floor = val;
            CFG_MAX_D2:  d2_ceil  = val;
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // wait for every result, then let the pipeline settle
    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_forces.size() > 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic body_pair_t random_pair();
        body_pair_t p;
        logic [31:0] base_x, base_y;
        int kind;
        kind = $urandom_range(99);
        p.ma = $urandom() >> $urandom_range(31);
        p.mb = $urandom() >> $urandom_range(31);
        if (kind < 30) begin
            // full range positions
            p.ax = $urandom();
            p.ay = $urandom();
            p.bx = $urandom();
            p.by = $urandom();
        end else if (kind < 35) begin
            // coincident
            p.ax = $urandom();
            p.ay = $urandom();
            p.bx = p.ax;
            p.by = p.ay;
        end else begin
            // nearby bodies with spread scaled at random
            base_x = $urandom();
            base_y = $urandom();
            p.ax = base_x;
            p.ay = base_y;
            p.bx = base_x + ($signed($urandom()) >>> $urandom_range(31, 8));
            p.by = base_y + ($signed($urandom()) >>> $urandom_range(31, 8));
        end
        return p;
    endfunction

    task automatic random_run(input int n);
        for (int i = 0; i < n; i++) send_pair(random_pair(), 1'b0, '0);
        drain();
    endtask

    function automatic body_pair_t mk(input logic [31:0] ax, ay, bx, by, ma, mb);
        body_pair_t p;
        p.ax = ax; p.ay = ay; p.bx = bx; p.by = by; p.ma = ma; p.mb = mb;
        return p;
    endfunction

    // receiver: random backpressure, one long hold-off on request
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_cycles > 0) begin
                m_tready    <= 1'b0;
                hold_cycles = hold_cycles - 1;
            end else begin
                m_tready <= quiet ? 1'b1 : ($urandom_range(99) >= 30);
            end
        end
    end

    // result check against the oldest expectation
    always @(posedge aclk) begin
        force_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.fx  = m_tdata[31:0];
            got.fy  = m_tdata[63:32];
            got.sat = m_tuser;
            if (pending_forces.size() == 0) begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("unexpected result beat: fx=%h fy=%h sat=%b",
                             got.fx, got.fy, got.sat);
            end else begin
                want = pending_forces.pop_front();
                if (got !== want) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("mismatch: exp fx=%h fy=%h sat=%b  got fx=%h fy=%h sat=%b",
                                 want.fx, want.fy, want.sat, got.fx, got.fy, got.sat);
                end
            end
        end
    end

    // watchdog on cycles without any beat
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn)
            dead_cycles <= 0;
        else
            dead_cycles <= dead_cycles + 1;
        if (dead_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        stim_row_t table_rows[$];
        force_t    zero_force;
        zero_force  = '0;
        error_count = 0;
        quiet       = 0;
        hold_cycles = 0;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_GRAVITY;
        cfg_data  = '0;
        g_const   = GRAV_RST;
        d2_floor  = MIN_D2_RST;
        d2_ceil   = D2_MAX;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed rows: coincident ones typed, the rest predicted
        table_rows.push_back('{mk(0, 0, 0, 0, 0, 0), 1, zero_force});
        table_rows.push_back('{mk(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                                  32'h7FFF_FFFF, '1, '1), 1, zero_force});
        table_rows.push_back('{mk(0, 0, 32'h0001_0000, 0, 32'h0001_0000,
                                  32'h0001_0000), 0, zero_force});
        table_rows.push_back('{mk(0, 0, 32'hFFFF_0000, 0, 32'h0001_0000,
                                  32'h0001_0000), 0, zero_force});
        table_rows.push_back('{mk(0, 0, 0, 32'h0003_0000, 32'h0010_0000,
                                  32'h0002_0000), 0, zero_force});
        table_rows.push_back('{mk(0, 0, 0, 32'hFFFD_0000, 32'h0010_0000,
                                  32'h0002_0000), 0, zero_force});
        table_rows.push_back('{mk(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                                  32'h7FFF_FFFF, '1, '1), 0, zero_force});
        table_rows.push_back('{mk(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                                  32'h8000_0000, '1, '1), 0, zero_force});
        table_rows.push_back('{mk(0, 0, 1, 0, '1, '1), 0, zero_force});
        table_rows.push_back('{mk(0, 0, 0, 32'hFFFF_FFFF, '1, '1), 0, zero_force});
        table_rows.push_back('{mk(0, 0, 1, 1, 1, 1), 0, zero_force});
        table_rows.push_back('{mk(32'h0000_8000, 32'h0000_4000, 32'h0000_9000,
                                  32'h0000_3000, 32'h1000_0000, 32'h0100_0000), 0, zero_force});
        table_rows.push_back('{mk(0, 0, 32'h0400_0000, 32'h0300_0000, 32'h0001_0000,
                                  32'h0001_0000), 0, zero_force});
        table_rows.push_back('{mk(32'h1234_5678, 32'h9ABC_DEF0, 32'h0FED_CBA9,
                                  32'h8765_4321, 32'hDEAD_BEEF, 32'h0000_BEEF), 0, zero_force});
        foreach (table_rows[i]) send_pair(table_rows[i].pair, table_rows[i].typed,
                                          table_rows[i].want);
        drain();

        // reset config, random; long output hold-off with input offered
        hold_cycles = 400;
        random_run(RAND_PER_PHASE);

        // strongest G, zero bounds: divisor raised to one LSB
        write_reg(CFG_GRAVITY, 48'hFFFF_FFFF);
        write_reg(CFG_MIN_D2, 48'd0);
        write_reg(CFG_MAX_D2, 48'd0);
        send_pair(mk(0, 0, 32'h0001_0000, 0, 1, 1), 0, zero_force);
        send_pair(mk(0, 0, 1, 1, 32'h0000_0100, 32'h0000_0100), 0, zero_force);
        random_run(RAND_PER_PHASE / 2);

        // crossed bounds, no idling on either side
        quiet = 1;
        write_reg(CFG_GRAVITY, 48'h0000_0400);
        write_reg(CFG_MIN_D2, D2_MAX);
        write_reg(CFG_MAX_D2, 48'h0000_0010_0000);
        write_reg(CFG_UNUSED, 48'hABCD_0000_1234);
        random_run(RAND_PER_PHASE);
        quiet = 0;

        // zero G
        write_reg(CFG_GRAVITY, 48'd0);
        write_reg(CFG_MIN_D2, 48'd1);
        write_reg(CFG_MAX_D2, D2_MAX);
        random_run(RAND_PER_PHASE / 2);

        // random settings
        for (int k = 0; k < 3; k++) begin
            write_reg(CFG_GRAVITY, 48'($urandom()));
            write_reg(CFG_MIN_D2, 48'({$urandom(), $urandom()} >> $urandom_range(47, 16)));
            write_reg(CFG_MAX_D2, 48'({$urandom(), $urandom()} >> $urandom_range(16, 0)));
            random_run(RAND_PER_PHASE / 2);
        end

        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
